@@ rtl/fltw_pkg.sv @@
`timescale 1ns / 1ps

package fltw_pkg;

    // Field widths
    localparam int unsigned VA_W    = 48;
    localparam int unsigned PA_W    = 48;
    localparam int unsigned ROOT_W  = 36;
    localparam int unsigned ENTRY_W = 64;
    localparam int unsigned BYTES_W = 31;
    localparam int unsigned IDX_W   = 9;

    // Entry flag bits
    localparam int unsigned PRESENT_BIT = 0;
    localparam int unsigned LARGE_BIT   = 7;

    // Page lengths in bytes
    localparam logic [BYTES_W-1:0] PAGE_1G_BYTES = 31'h4000_0000;
    localparam logic [BYTES_W-1:0] PAGE_2M_BYTES = 31'h0020_0000;
    localparam logic [BYTES_W-1:0] PAGE_4K_BYTES = 31'h0000_1000;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Request codes; code 3 is unused
    typedef enum logic [1:0] {
        REQ_TRANSLATE = 2'd0,
        REQ_ENTRY     = 2'd1,
        REQ_FAULT     = 2'd2
    } req_type_t;

    // Walk level: which table entry is awaited
    typedef enum logic [2:0] {
        LVL_IDLE = 3'd0,
        LVL_PT   = 3'd1,
        LVL_PD   = 3'd2,
        LVL_PDPT = 3'd3,
        LVL_PML4 = 3'd4
    } walk_level_t;

    typedef enum logic [1:0] {
        SIZE_4K = 2'd0,
        SIZE_2M = 2'd1,
        SIZE_1G = 2'd2
    } page_size_t;

    // One result of a step
    typedef struct packed {
        logic                has_result;
        logic                out_kind;
        logic [PA_W-1:0]     read_addr;
        logic [PA_W-1:0]     phys_addr;
        logic [1:0]          page_size;
        logic [BYTES_W-1:0]  bytes_to_page_end;
        logic                fault;
    } step_result_t;

    // 9-bit table index for a level, taken from the virtual address
    function automatic logic [IDX_W-1:0] level_index(input walk_level_t lvl,
                                                     input logic [VA_W-1:0] va);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = '0;
        endcase
        return idx;
    endfunction

endpackage

@@ rtl/fltw_step.sv @@
`timescale 1ns / 1ps

module fltw_step
    import fltw_pkg::*;
(
    input  logic [1:0]          req_type,
    input  logic [VA_W-1:0]     virt_addr,
    input  logic [ENTRY_W-1:0]  entry_data,
    input  logic [ROOT_W-1:0]   table_root_frame,
    input  walk_level_t         level,
    input  logic [VA_W-1:0]     saved_va,
    output walk_level_t         level_next,
    output logic [VA_W-1:0]     saved_va_next,
    output step_result_t        result
);

    logic        present;
    logic        large_page;
    walk_level_t lower_level;

    assign present     = entry_data[PRESENT_BIT];
    assign large_page  = entry_data[LARGE_BIT];
    assign lower_level = walk_level_t'(level - 3'd1);

    // Next walk level and saved address
    always_comb
    begin
        level_next    = level;
        saved_va_next = saved_va;
        unique case (req_type)
            REQ_TRANSLATE:
            begin
                level_next    = LVL_PML4;
                saved_va_next = virt_addr;
            end
            REQ_ENTRY:
            begin
                if (level != LVL_IDLE)
                begin
                    priority if (!present)
                        level_next = LVL_IDLE;
                    else if ((level == LVL_PDPT || level == LVL_PD) && large_page)
                        level_next = LVL_IDLE;
                    else if (level == LVL_PT)
                        level_next = LVL_IDLE;
                    else
                        level_next = lower_level;
                end
            end
            REQ_FAULT:
                level_next = LVL_IDLE;
            default:
                level_next = level;
        endcase
    end

    // Result item
    always_comb
    begin
        result = '0;
        unique case (req_type)
            REQ_TRANSLATE:
            begin
                result.has_result = 1'b1;
                result.out_kind   = KIND_READ;
                result.read_addr  = {table_root_frame,
                                     level_index(LVL_PML4, virt_addr), 3'b000};
            end
            REQ_ENTRY:
            begin
                if (level != LVL_IDLE)
                begin
                    result.has_result = 1'b1;
                    result.out_kind   = KIND_DONE;
                    priority if (!present)
                        result.fault = 1'b1;
                    else if (level == LVL_PDPT && large_page)
                    begin
                        result.phys_addr         = {entry_data[47:30], saved_va[29:0]};
                        result.page_size         = SIZE_1G;
                        result.bytes_to_page_end = PAGE_1G_BYTES
                                                   - {1'b0, saved_va[29:0]};
                    end
                    else if (level == LVL_PD && large_page)
                    begin
                        result.phys_addr         = {entry_data[47:21], saved_va[20:0]};
                        result.page_size         = SIZE_2M;
                        result.bytes_to_page_end = PAGE_2M_BYTES
                                                   - {10'b0, saved_va[20:0]};
                    end
                    else if (level == LVL_PT)
                    begin
                        result.phys_addr         = {entry_data[47:12], saved_va[11:0]};
                        result.page_size         = SIZE_4K;
                        result.bytes_to_page_end = PAGE_4K_BYTES
                                                   - {19'b0, saved_va[11:0]};
                    end
                    else
                    begin
                        // descend one level
                        result.out_kind  = KIND_READ;
                        result.read_addr = {entry_data[47:12],
                                            level_index(lower_level, saved_va), 3'b000};
                    end
                end
            end
            REQ_FAULT:
            begin
                if (level != LVL_IDLE)
                begin
                    result.has_result = 1'b1;
                    result.out_kind   = KIND_DONE;
                    result.fault      = 1'b1;
                end
            end
            default:
                result = '0;
        endcase
    end

endmodule

@@ rtl/four_level_page_table_walker_top.sv @@
// Input transfer to result passes through one input register and one result register.
// Throughput: one item per cycle; each item is resolved by single-pass logic on the input
// register, and a result leaving the output register in the same cycle does not block the
// next transfer; a stalled result holds the input register, which then stalls the input.
// Walk length is set by the memory answering the read requests, one round trip per level.
// Reset (rst_n low, asynchronous): walk idle, saved address and root frame cleared, no
// item held.
`timescale 1ns / 1ps

module four_level_page_table_walker_top
    import fltw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [ROOT_W-1:0]   cfg_wr_data,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [VA_W-1:0]     virt_addr,
    input  logic [ENTRY_W-1:0]  entry_data,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                out_kind,
    output logic [PA_W-1:0]     read_addr,
    output logic [PA_W-1:0]     phys_addr,
    output logic [1:0]          page_size,
    output logic [BYTES_W-1:0]  bytes_to_page_end,
    output logic                fault
);

    logic [ROOT_W-1:0]  root_reg;
    logic               in_vld_reg;
    logic [1:0]         req_reg;
    logic [VA_W-1:0]    va_in_reg;
    logic [ENTRY_W-1:0] entry_reg;
    walk_level_t        level_reg;
    walk_level_t        level_next;
    logic [VA_W-1:0]    saved_va_reg;
    logic [VA_W-1:0]    saved_va_next;
    step_result_t       step_res;
    logic               out_vld_reg;
    logic               out_vld_next;
    step_result_t       out_reg;
    logic               advance;
    logic               in_xfer;

    // Handshake: held item moves on when the result register is free or being emptied
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    // Root frame register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root_reg <= '0;
        else if (cfg_wr_en)
            root_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_xfer)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg   <= req_type;
            va_in_reg <= virt_addr;
            entry_reg <= entry_data;
        end
    end

    // Step logic
    fltw_step u_step (
        .req_type         (req_reg),
        .virt_addr        (va_in_reg),
        .entry_data       (entry_reg),
        .table_root_frame (root_reg),
        .level            (level_reg),
        .saved_va         (saved_va_reg),
        .level_next       (level_next),
        .saved_va_next    (saved_va_next),
        .result           (step_res)
    );

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= LVL_IDLE;
            saved_va_reg <= '0;
        end
        else if (advance)
        begin
            level_reg    <= level_next;
            saved_va_reg <= saved_va_next;
        end
    end

    // Result register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = step_res.has_result;
        else if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_res.has_result)
            out_reg <= step_res;
    end

    assign out_valid         = out_vld_reg;
    assign out_kind          = out_reg.out_kind;
    assign read_addr         = out_reg.read_addr;
    assign phys_addr         = out_reg.phys_addr;
    assign page_size         = out_reg.page_size;
    assign bytes_to_page_end = out_reg.bytes_to_page_end;
    assign fault             = out_reg.fault;

    // Checks
    a_translate_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && req_reg == REQ_TRANSLATE) |=> level_reg == LVL_PML4)
        else $error("translate did not start a walk at the top level");

    a_done_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.has_result && step_res.out_kind == KIND_DONE)
        |=> level_reg == LVL_IDLE)
        else $error("finished translation left the walk running");

    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault) |-> (phys_addr == '0 && bytes_to_page_end == '0
                                  && out_kind == KIND_DONE))
        else $error("faulted result carries an address");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && level_reg == LVL_IDLE && req_reg != REQ_TRANSLATE)
        |-> !step_res.has_result)
        else $error("result produced while no walk was running");

endmodule

@@ tb/sv/walk_checker.sv @@
`timescale 1ns / 1ps

module walk_checker
    import fltw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [ROOT_W-1:0]   cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [VA_W-1:0]     virt_addr,
    input  logic [ENTRY_W-1:0]  entry_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                out_kind,
    input  logic [PA_W-1:0]     read_addr,
    input  logic [PA_W-1:0]     phys_addr,
    input  logic [1:0]          page_size,
    input  logic [BYTES_W-1:0]  bytes_to_page_end,
    input  logic                fault,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen
);

    typedef struct packed {
        logic                emits;
        logic                kind;
        logic [PA_W-1:0]     read_addr;
        logic [PA_W-1:0]     phys_addr;
        logic [1:0]          psize;
        logic [BYTES_W-1:0]  bytes_left;
        logic                fault;
    } walk_result_t;

    // Shadow of the walker state
    logic [ROOT_W-1:0]  root_frame;
    walk_level_t        cur_level;
    logic [VA_W-1:0]    cur_va;

    walk_result_t       expected_q[$];
    walk_result_t       want;
    walk_result_t       fresh;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_val));
    endtask

    // Entry address: table base plus 8 bytes per slot; slot is the VA's 9-bit
    // field for the level (PT at bit 12, each level up 9 bits higher)
    function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0] base,
                                                   input walk_level_t lvl);
        int unsigned     shift;
        logic [VA_W-1:0] part;
        shift = 12 + 9 * (int'(lvl) - 1);
        part  = cur_va >> shift;
        return base + {part[8:0], 3'b000};
    endfunction

    // Successful end of a walk at any page size
    function automatic walk_result_t page_done(input logic [PA_W-1:0] base,
                                               input logic [BYTES_W-1:0] len,
                                               input page_size_t sz);
        walk_result_t    r;
        logic [PA_W-1:0] off;
        r            = '0;
        off          = cur_va & (PA_W'(len) - 1'b1);
        r.emits      = 1'b1;
        r.kind       = KIND_DONE;
        r.phys_addr  = base + off;
        r.psize      = sz;
        r.bytes_left = len - BYTES_W'(off);
        cur_level    = LVL_IDLE;
        return r;
    endfunction

    // One accepted item: advance the shadow walk, return what should come out
    function automatic walk_result_t walk_step(input logic [1:0] req,
                                               input logic [VA_W-1:0] va,
                                               input logic [ENTRY_W-1:0] ent);
        walk_result_t r;
        r = '0;
        if (req == REQ_TRANSLATE)
        begin
            cur_va      = va;
            cur_level   = LVL_PML4;
            r.emits     = 1'b1;
            r.kind      = KIND_READ;
            r.read_addr = entry_addr({root_frame, 12'h000}, LVL_PML4);
        end
        else if ((req == REQ_ENTRY || req == REQ_FAULT) && cur_level != LVL_IDLE)
        begin
            if (req == REQ_FAULT || !ent[PRESENT_BIT])
            begin
                r.emits   = 1'b1;
                r.kind    = KIND_DONE;
                r.fault   = 1'b1;
                cur_level = LVL_IDLE;
            end
            else if (ent[LARGE_BIT] && cur_level == LVL_PDPT)
                r = page_done({ent[47:30], 30'h0}, PAGE_1G_BYTES, SIZE_1G);
            else if (ent[LARGE_BIT] && cur_level == LVL_PD)
                r = page_done({ent[47:21], 21'h0}, PAGE_2M_BYTES, SIZE_2M);
            else if (cur_level == LVL_PT)
                r = page_done({ent[47:12], 12'h000}, PAGE_4K_BYTES, SIZE_4K);
            else
            begin
                // descend one level; large bit at PML4 is ignored
                cur_level   = walk_level_t'(cur_level - 1'b1);
                r.emits     = 1'b1;
                r.kind      = KIND_READ;
                r.read_addr = entry_addr({ent[47:12], 12'h000}, cur_level);
            end
        end
        // idle entries/faults and the unused code leave everything alone
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_frame = '0;
            cur_level  = LVL_IDLE;
            cur_va     = '0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            // result side
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected result transfer, kind %0b", out_kind));
                else
                begin
                    want = expected_q.pop_front();
                    check_field("out_kind", 64'(out_kind), 64'(want.kind));
                    check_field("read_addr", 64'(read_addr), 64'(want.read_addr));
                    check_field("phys_addr", 64'(phys_addr), 64'(want.phys_addr));
                    check_field("page_size", 64'(page_size), 64'(want.psize));
                    check_field("bytes_to_page_end", 64'(bytes_to_page_end),
                                64'(want.bytes_left));
                    check_field("fault", 64'(fault), 64'(want.fault));
                end
            end

            if (cfg_wr_en)
                root_frame = cfg_wr_data;

            // request side
            if (in_valid && !in_stall)
            begin
                fresh = walk_step(req_type, virt_addr, entry_data);
                if (fresh.emits)
                    expected_q.push_back(fresh);
            end

            pending <= expected_q.size();
        end
    end

endmodule

@@ tb/sv/tb_four_level_page_table_walker_top.sv @@
`timescale 1ns / 1ps

module tb_four_level_page_table_walker_top;
    import fltw_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         RANDOM_PER_PHASE = 160;
    localparam int         PHASES = 6;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [ROOT_W-1:0]   cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          req_type = REQ_TRANSLATE;
    logic [VA_W-1:0]     virt_addr = '0;
    logic [ENTRY_W-1:0]  entry_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                out_kind;
    logic [PA_W-1:0]     read_addr;
    logic [PA_W-1:0]     phys_addr;
    logic [1:0]          page_size;
    logic [BYTES_W-1:0]  bytes_to_page_end;
    logic                fault;

    int fail_count;
    int pending;
    int results_seen;

    // Sender bookkeeping
    int burst_left = 4;
    int walk_depth = 0;
    int items_sent = 0;
    int items_ignored = 0;
    int walks_started = 0;

    // Receiver stall pattern
    int stall_mode = 0;
    int stall_left = 20;
    int stall_tick = 0;

    logic [ROOT_W-1:0] roots[PHASES];

    always #1 clk = ~clk;

    four_level_page_table_walker_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .req_type          (req_type),
        .virt_addr         (virt_addr),
        .entry_data        (entry_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_kind          (out_kind),
        .read_addr         (read_addr),
        .phys_addr         (phys_addr),
        .page_size         (page_size),
        .bytes_to_page_end (bytes_to_page_end),
        .fault             (fault)
    );

    walk_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .req_type          (req_type),
        .virt_addr         (virt_addr),
        .entry_data        (entry_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_kind          (out_kind),
        .read_addr         (read_addr),
        .phys_addr         (phys_addr),
        .page_size         (page_size),
        .bytes_to_page_end (bytes_to_page_end),
        .fault             (fault),
        .fail_count        (fail_count),
        .pending           (pending),
        .results_seen      (results_seen)
    );

    // Receiver: alternates between free-running, light, periodic and heavy stalling
    always @(posedge clk)
    begin
        stall_tick++;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 60);
        end
        else
            stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 25);
            2: out_stall <= (stall_tick % 5 < 2);
            default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
    end

    function automatic logic [VA_W-1:0] rand_va();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            default: return raw[VA_W-1:0];
        endcase
    endfunction

    // One transfer on the request channel, then burst/gap handling
    task automatic send_item(input logic [1:0] rt, input logic [VA_W-1:0] va,
                             input logic [ENTRY_W-1:0] ent);
        in_valid   <= 1'b1;
        req_type   <= rt;
        virt_addr  <= va;
        entry_data <= ent;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        // track where the walk stands so sequences stay well formed
        items_sent++;
        if (rt == REQ_TRANSLATE)
        begin
            walk_depth = 4;
            walks_started++;
        end
        else if (rt == REQ_UNUSED || walk_depth == 0)
            items_ignored++;
        else if (rt == REQ_FAULT || !ent[PRESENT_BIT])
            walk_depth = 0;
        else if (ent[LARGE_BIT] && (walk_depth == 3 || walk_depth == 2))
            walk_depth = 0;
        else
            walk_depth--;

        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // Drain every expected result, then allow the pipeline to settle;
    // the first edge lets the checker's count include the last transfer
    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_root(input logic [ROOT_W-1:0] frame);
        in_valid <= 1'b0;
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= frame;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Translate, then entries until the walk ends, with occasional breaks
    task automatic random_walk();
        logic [ENTRY_W-1:0] ent;
        int                 pick;
        send_item(REQ_TRANSLATE, rand_va(), {$urandom(), $urandom()});
        while (walk_depth != 0)
        begin
            pick = $urandom_range(0, 99);
            ent  = {$urandom(), $urandom()};
            if (pick < 4)
                send_item(REQ_FAULT, rand_va(), ent);
            else if (pick < 7)
                send_item(REQ_TRANSLATE, rand_va(), ent);
            else if (pick < 9)
                send_item(REQ_UNUSED, rand_va(), ent);
            else
            begin
                ent[PRESENT_BIT] = ($urandom_range(0, 9) != 0);
                ent[LARGE_BIT]   = ($urandom_range(0, 9) < 4);
                send_item(REQ_ENTRY, rand_va(), ent);
            end
        end
    endtask

    task automatic directed_walks();
        // 1 GiB page, large bit at PML4 ignored, all-ones entry
        send_item(REQ_TRANSLATE, 48'h0, 64'h0);
        send_item(REQ_ENTRY, 48'h0, 64'h0000_0000_0000_0081);
        send_item(REQ_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        // full 4 KiB walk at the top of the address space, large bit at PT ignored
        send_item(REQ_TRANSLATE, 48'hFFFF_FFFF_FFFF, 64'h0);
        send_item(REQ_ENTRY, 48'h0, 64'h0000_FFFF_FFFF_F001);
        send_item(REQ_ENTRY, 48'h0, 64'h0000_FFFF_FFFF_F001);
        send_item(REQ_ENTRY, 48'h0, 64'h0000_0000_0000_1001);
        send_item(REQ_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        // 2 MiB page
        send_item(REQ_TRANSLATE, 48'h0000_3FE0_1234, 64'h0);
        send_item(REQ_ENTRY, 48'h0, 64'h0000_0000_0000_0001);
        send_item(REQ_ENTRY, 48'h0, 64'h0000_0000_0000_0001);
        send_item(REQ_ENTRY, 48'h0, 64'h8000_0000_0020_0081);
        // not present at the top level
        send_item(REQ_TRANSLATE, 48'h8000_0000_0000, 64'h0);
        send_item(REQ_ENTRY, 48'h0, 64'h0);
        // entry and fault while idle
        send_item(REQ_ENTRY, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(REQ_FAULT, 48'h0, 64'h0);
        // memory read fault mid-walk
        send_item(REQ_TRANSLATE, 48'h1234_5678_9ABC, 64'h0);
        send_item(REQ_ENTRY, 48'h0, 64'h0000_0000_0000_0001);
        send_item(REQ_FAULT, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        // new translate drops a walk, unused code ignored, not-present ends it
        send_item(REQ_TRANSLATE, 48'h7FFF_FFFF_FFFF, 64'h0);
        send_item(REQ_ENTRY, 48'h0, 64'h0000_0000_0000_0001);
        send_item(REQ_TRANSLATE, 48'h0000_0000_0FFF, 64'h0);
        send_item(REQ_UNUSED, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(REQ_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFE);
    endtask

    initial
    begin
        int counted;
        logic [63:0] raw;

        raw       = {$urandom(), $urandom()};
        roots[0]  = '1;
        roots[1]  = '0;
        roots[2]  = 36'hA_AAAA_AAAA;
        roots[3]  = 36'h5_5555_5555;
        roots[4]  = raw[ROOT_W-1:0];
        roots[5]  = '1;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_root(roots[ph]);
            if (ph == 0)
                directed_walks();
            else
            begin
                counted = 0;
                while (counted < RANDOM_PER_PHASE)
                begin
                    if ($urandom_range(0, 9) < 8)
                        random_walk();
                    else
                        repeat ($urandom_range(1, 4))
                            send_item(2'($urandom_range(0, 3)), rand_va(),
                                      {$urandom(), $urandom()});
                    counted = items_sent - items_ignored;
                    counted = counted - (ph - 1) * RANDOM_PER_PHASE - 24 + 3;
                end
            end
        end

        in_valid <= 1'b0;
        wait_idle();

        $display("Sent %0d request transfers (%0d ignored), %0d walks over %0d root frames",
                 items_sent, items_ignored, walks_started, PHASES);
        $display("Checked %0d result transfers against the predicted walk", results_seen);
        if (fail_count == 0 && pending == 0)
            $display("four_level_page_table_walker_top verification clean");
        else
            $display("four_level_page_table_walker_top verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("Timed out waiting for the walker");
        $display("four_level_page_table_walker_top verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/fltw_pkg.sv
rtl/fltw_step.sv
rtl/four_level_page_table_walker_top.sv
tb/sv/walk_checker.sv
tb/sv/tb_four_level_page_table_walker_top.sv
